// ===== src/oaht_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the hash table unit.
package oaht_pkg;

   // Fixed field widths
   localparam int REQ_W       = 2;
   localparam int KEY_TEXT_W  = 64;
   localparam int LEN_W       = 4;
   localparam int KEY_VALUE_W = 31;
   localparam int RSP_W       = 3;
   localparam int POS_W       = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 2;

   // Default sizes
   localparam int DEF_SLOTS         = 16;
   localparam int DEF_MAX_KEY_CHARS = 8;

   // String hash
   localparam int       HASH_W    = 32;
   localparam int       FOLD_TOP  = 28;
   localparam int       FOLD_ADD  = 10;
   localparam int       FOLD_BITS = 4;
   localparam bit [3:0] FOLD_MASK = 4'hF;
   localparam int       STEP_MOD  = 7;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

   // Result codes
   localparam logic [RSP_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [RSP_W-1:0] ST_FULL     = 3'd1;
   localparam logic [RSP_W-1:0] ST_FOUND    = 3'd2;
   localparam logic [RSP_W-1:0] ST_MISSING  = 3'd3;
   localparam logic [RSP_W-1:0] ST_CLEARED  = 3'd4;

   // Probe modes
   localparam logic [1:0] PROBE_LINEAR = 2'd0;
   localparam logic [1:0] PROBE_QUAD   = 2'd1;
   localparam logic [1:0] PROBE_DOUBLE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGER_KEYS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE   = 1'b1;

   typedef struct packed {
      logic             load;
      logic             hash_step;
      logic             rem_start;
      logic             probe_init;
      logic             probe_next;
      logic             write_slot;
      logic             sweep_start;
      logic             sweep_step;
      logic             respond;
      logic             use_pos;
      logic [RSP_W-1:0] rsp_code;
   } oaht_cmd_type;

   typedef struct packed {
      logic hash_last;
      logic rem_done;
      logic slot_empty;
      logic slot_match;
      logic next_home;
      logic sweep_last;
      logic cfg_wipe;
   } oaht_status_type;

endpackage

// ===== src/open_addressing_hash_table_unit.sv =====
// Top level of the open-addressing hash table unit.
//
// Usage: drive req_type and the key fields with start high; the item is taken at a
// rising edge where start is high and busy is low. Insert (0) and find (1) hash the
// key, pick a home slot and probe the table; clear (2) empties it. Each item yields
// one result: rsp_valid is high for exactly one cycle with rsp_status and
// rsp_position, and the receiver cannot hold it off. A new item may be started in
// the cycle the previous result is shown; one item is in flight at a time.
// Steps: insert/find hash the len key characters one a cycle, start the remainders,
// take the reciprocal-multiply remainders of home slot and double-hash step, load the
// probe, then run up to SLOTS probes with one slot-store read each, and show the
// result. Clear sweeps every slot; an unknown request type is answered as missing.
// Configuration (csr_*) is taken at any time with csr_ready tied high; writing
// integer_keys also empties the table, a sweep that holds busy high while it runs.
// After reset the same sweep runs, with busy high, before the first item is taken.
module open_addressing_hash_table_unit #(
   parameter int SLOTS         = oaht_pkg::DEF_SLOTS,
   parameter int MAX_KEY_CHARS = oaht_pkg::DEF_MAX_KEY_CHARS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [oaht_pkg::REQ_W-1:0]       req_type,
   input  logic [oaht_pkg::KEY_TEXT_W-1:0]  req_key_text,
   input  logic [oaht_pkg::LEN_W-1:0]       req_key_length,
   input  logic [oaht_pkg::KEY_VALUE_W-1:0] req_key_value,
   output logic                             rsp_valid,
   output logic [oaht_pkg::RSP_W-1:0]       rsp_status,
   output logic [oaht_pkg::POS_W-1:0]       rsp_position,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [oaht_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [oaht_pkg::CSR_DATA_W-1:0]  csr_data
);
   import oaht_pkg::*;

   oaht_cmd_type    cmd;
   oaht_status_type status;

   oaht_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_type (req_type),
      .cmd      (cmd),
      .status   (status)
   );

   oaht_dp #(
      .SLOTS         (SLOTS),
      .MAX_KEY_CHARS (MAX_KEY_CHARS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_key_text   (req_key_text),
      .req_key_length (req_key_length),
      .req_key_value  (req_key_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position)
   );

endmodule

// ===== src/oaht_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/oaht_rem.sv =====
// Remainder by a constant divisor through reciprocal multiplication.
module oaht_rem #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR    = 16,
   localparam int REM_W = $clog2(DIVISOR)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   output logic                  done,
   output logic [REM_W-1:0]      remainder
);

   // floor(n / DIVISOR) equals (n * RECIP) >> SHIFT for every DIVIDEND_W-bit n
   localparam int SHIFT  = DIVIDEND_W + REM_W;
   localparam int MUL_W  = DIVIDEND_W + 2;
   localparam int PROD_W = DIVIDEND_W + MUL_W;
   localparam logic [MUL_W-1:0] RECIP =
      MUL_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic [REM_W-1:0] DIV_LOW = REM_W'(DIVISOR);

   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [REM_W-1:0]      quot_ff, quot_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [PROD_W-1:0]     prod;

   always_comb begin
      prod    = PROD_W'(num_ff) * PROD_W'(RECIP);
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         num_in = dividend;
         cnt_in = 2'd2;
      end else if (cnt_ff == 2'd2) begin
         // only the low quotient bits reach the remainder
         quot_in = REM_W'(prod >> SHIFT);
         cnt_in  = 2'd1;
      end else if (cnt_ff == 2'd1) begin
         rem_in = num_ff[REM_W-1:0] - quot_ff * DIV_LOW;
         cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = (cnt_ff == '0);
   assign remainder = rem_ff;

endmodule

// ===== src/oaht_dp.sv =====
// Datapath: key latch, string hash, remainder units, probe arithmetic, slot stores, registers.
module oaht_dp #(
   parameter int SLOTS         = oaht_pkg::DEF_SLOTS,
   parameter int MAX_KEY_CHARS = oaht_pkg::DEF_MAX_KEY_CHARS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  oaht_pkg::oaht_cmd_type             cmd,
   output oaht_pkg::oaht_status_type          status,
   input  logic [oaht_pkg::KEY_TEXT_W-1:0]    req_key_text,
   input  logic [oaht_pkg::LEN_W-1:0]         req_key_length,
   input  logic [oaht_pkg::KEY_VALUE_W-1:0]   req_key_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [oaht_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [oaht_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               rsp_valid,
   output logic [oaht_pkg::RSP_W-1:0]         rsp_status,
   output logic [oaht_pkg::POS_W-1:0]         rsp_position
);
   import oaht_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int SUM_W  = IDX_W + 1;
   localparam int STEP_W = IDX_W + 3;
   localparam int KEY_W  = 8 * MAX_KEY_CHARS;
   localparam int CNT_W  = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
   localparam int R7_W   = $clog2(STEP_MOD);

   // Registers
   logic                   integer_keys_ff, integer_keys_in;
   logic [1:0]             probe_mode_ff, probe_mode_in;
   logic [KEY_W-1:0]       text_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [KEY_VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [HASH_W-1:0]      hash_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [IDX_W-1:0]       dstep_ff;
   logic [IDX_W-1:0]       qinc_ff;
   logic [IDX_W-1:0]       sweep_ff;
   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_status_ff;
   logic [POS_W-1:0]       rsp_position_ff;

   // Combinational
   logic [LEN_W-1:0]       len_eff;
   logic [KEY_W-1:0]       text_mask;
   logic [7:0]             char_sel;
   logic [HASH_W-1:0]      h_add, h_rot, h_fold, hash_in;
   logic [FOLD_BITS-1:0]   fold_x;
   logic [HASH_W-1:0]      home_dividend;
   logic                   home_done, r7_done;
   logic [IDX_W-1:0]       home;
   logic [R7_W-1:0]        r7;
   logic [R7_W-1:0]        step7;
   logic [STEP_W-1:0]      step_red;
   logic [IDX_W-1:0]       probe_inc;
   logic [SUM_W-1:0]       idx_sum, q_sum;
   logic [IDX_W-1:0]       next_idx, qinc_in;
   logic [IDX_W+POS_W-1:0] idx_ext;
   logic [KEY_W-1:0]       key_rd;
   logic [LEN_W-1:0]       len_rd;
   logic                   len_we;
   logic [IDX_W-1:0]       len_waddr;
   logic [LEN_W-1:0]       len_wdata;

   // Key normalisation: clamp the length, zero bytes past it
   always_comb begin
      if (req_key_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (req_key_length > LEN_W'(MAX_KEY_CHARS)) begin
         len_eff = LEN_W'(MAX_KEY_CHARS);
      end else begin
         len_eff = req_key_length;
      end
      for (int i = 0; i < MAX_KEY_CHARS; i++) begin
         text_mask[8*i +: 8] = (LEN_W'(i) < len_eff) ? req_key_text[8*i +: 8] : 8'h00;
      end
   end

   // One character of the shift-fold hash per step, last character first
   always_comb begin
      char_sel = text_ff[8*cnt_ff +: 8];
      h_add    = hash_ff + HASH_W'(char_sel);
      fold_x   = FOLD_BITS'((h_add >> FOLD_TOP) & HASH_W'(FOLD_MASK));
      h_rot    = (h_add << FOLD_BITS) | HASH_W'(fold_x);
      h_fold   = h_rot + (HASH_W'(fold_x) << FOLD_ADD);
      hash_in  = (cnt_ff == '0) ? h_add : h_fold;
   end

   assign home_dividend = integer_keys_ff ? {1'b0, value_ff} : hash_ff;

   oaht_rem #(
      .DIVIDEND_W (HASH_W),
      .DIVISOR    (SLOTS)
   ) u_rem_home (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.rem_start),
      .dividend  (home_dividend),
      .done      (home_done),
      .remainder (home)
   );

   oaht_rem #(
      .DIVIDEND_W (HASH_W),
      .DIVISOR    (STEP_MOD)
   ) u_rem_step (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.rem_start),
      .dividend  (hash_ff),
      .done      (r7_done),
      .remainder (r7)
   );

   // Double-hash step, then reduce it below the table size
   always_comb begin
      step7    = (r7 == '0) ? '0 : (R7_W'(STEP_MOD) - r7);
      step_red = STEP_W'(step7);
      for (int i = 0; i < 3; i++) begin
         if (step_red >= STEP_W'(SLOTS)) begin
            step_red = step_red - STEP_W'(SLOTS);
         end
      end
   end

   // Next probe slot: add the per-probe increment, wrap once
   always_comb begin
      case (probe_mode_ff)
         PROBE_QUAD:   probe_inc = qinc_ff;
         PROBE_DOUBLE: probe_inc = dstep_ff;
         default:      probe_inc = IDX_W'(1);
      endcase
      idx_sum = {1'b0, idx_ff} + {1'b0, probe_inc};
      if (idx_sum >= SUM_W'(SLOTS)) begin
         idx_sum = idx_sum - SUM_W'(SLOTS);
      end
      next_idx = idx_sum[IDX_W-1:0];
      // quadratic offsets grow by 2k-1, kept reduced
      q_sum = {1'b0, qinc_ff} + SUM_W'(2);
      if (q_sum >= SUM_W'(SLOTS)) begin
         q_sum = q_sum - SUM_W'(SLOTS);
      end
      qinc_in = q_sum[IDX_W-1:0];
   end

   // Configuration registers
   always_comb begin
      integer_keys_in = integer_keys_ff;
      probe_mode_in   = probe_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INTEGER_KEYS: integer_keys_in = csr_data[0];
            CSR_PROBE_MODE:   probe_mode_in   = csr_data;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integer_keys_ff <= 1'b1;
         probe_mode_ff   <= PROBE_LINEAR;
         rsp_valid_ff    <= 1'b0;
      end else begin
         integer_keys_ff <= integer_keys_in;
         probe_mode_ff   <= probe_mode_in;
         rsp_valid_ff    <= cmd.respond;
      end
   end

   assign idx_ext = {{POS_W{1'b0}}, idx_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         text_ff  <= text_mask;
         len_ff   <= len_eff;
         value_ff <= req_key_value;
         cnt_ff   <= CNT_W'(len_eff - 1'b1);
         hash_ff  <= '0;
      end else if (cmd.hash_step) begin
         hash_ff <= hash_in;
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (cmd.probe_init) begin
         idx_ff   <= home;
         dstep_ff <= step_red[IDX_W-1:0];
         qinc_ff  <= IDX_W'(1);
      end else if (cmd.probe_next) begin
         idx_ff  <= next_idx;
         qinc_ff <= qinc_in;
      end
      if (cmd.sweep_start) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
      if (cmd.respond) begin
         rsp_status_ff   <= cmd.rsp_code;
         rsp_position_ff <= cmd.use_pos ? idx_ext[POS_W-1:0] : '0;
      end
   end

   // Slot stores
   assign len_we    = cmd.sweep_step | cmd.write_slot;
   assign len_waddr = cmd.sweep_step ? sweep_ff : idx_ff;
   assign len_wdata = cmd.sweep_step ? '0 : len_ff;

   oaht_ram #(
      .WIDTH (KEY_W),
      .DEPTH (SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.write_slot),
      .wr_addr (idx_ff),
      .wr_data (text_ff),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   oaht_ram #(
      .WIDTH (LEN_W),
      .DEPTH (SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_addr (idx_ff),
      .rd_data (len_rd)
   );

   always_comb begin
      status.hash_last  = (cnt_ff == '0);
      status.rem_done   = home_done & r7_done;
      status.slot_empty = (len_rd == '0);
      status.slot_match = (len_rd == len_ff) && (key_rd == text_ff);
      status.next_home  = (next_idx == home);
      status.sweep_last = (sweep_ff == IDX_W'(SLOTS - 1));
      status.cfg_wipe   = csr_valid && (csr_index == CSR_INTEGER_KEYS);
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== src/oaht_ctrl.sv =====
// Controller state machine: sequences hashing, remainder, probing and clearing sweeps.
module oaht_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [oaht_pkg::REQ_W-1:0]    req_type,
   output oaht_pkg::oaht_cmd_type        cmd,
   input  oaht_pkg::oaht_status_type     status
);
   import oaht_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_HASH     = 3'd1;
   localparam logic [2:0] S_REM_GO   = 3'd2;
   localparam logic [2:0] S_REM_WAIT = 3'd3;
   localparam logic [2:0] S_INIT     = 3'd4;
   localparam logic [2:0] S_READ     = 3'd5;
   localparam logic [2:0] S_CHECK    = 3'd6;
   localparam logic [2:0] S_SWEEP    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       wipe_ff, wipe_in;
   logic       insert_ff, insert_in;
   logic       clear_rsp_ff, clear_rsp_in;

   assign busy = (state_ff != S_IDLE) || wipe_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      wipe_in      = wipe_ff | status.cfg_wipe;
      insert_in    = insert_ff;
      clear_rsp_in = clear_rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (wipe_ff) begin
               // empty the table after reset or a write to integer_keys
               cmd.sweep_start = 1'b1;
               wipe_in         = status.cfg_wipe;
               clear_rsp_in    = 1'b0;
               state_in        = S_SWEEP;
            end else if (start) begin
               cmd.load = 1'b1;
               case (req_type)
                  REQ_INSERT: begin
                     insert_in = 1'b1;
                     state_in  = S_HASH;
                  end
                  REQ_FIND: begin
                     insert_in = 1'b0;
                     state_in  = S_HASH;
                  end
                  REQ_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     clear_rsp_in    = 1'b1;
                     state_in        = S_SWEEP;
                  end
                  default: begin
                     cmd.respond  = 1'b1;
                     cmd.rsp_code = ST_MISSING;
                  end
               endcase
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (status.hash_last) begin
               state_in = S_REM_GO;
            end
         end
         S_REM_GO: begin
            cmd.rem_start = 1'b1;
            state_in      = S_REM_WAIT;
         end
         S_REM_WAIT: begin
            if (status.rem_done) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.probe_init = 1'b1;
            state_in       = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (insert_ff) begin
               if (status.slot_empty) begin
                  cmd.write_slot = 1'b1;
                  cmd.respond    = 1'b1;
                  cmd.use_pos    = 1'b1;
                  cmd.rsp_code   = ST_INSERTED;
                  state_in       = S_IDLE;
               end else if (status.next_home) begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_code = ST_FULL;
                  state_in     = S_IDLE;
               end else begin
                  cmd.probe_next = 1'b1;
                  state_in       = S_READ;
               end
            end else begin
               if (status.slot_empty || (!status.slot_match && status.next_home)) begin
                  cmd.respond  = 1'b1;
                  cmd.rsp_code = ST_MISSING;
                  state_in     = S_IDLE;
               end else if (status.slot_match) begin
                  cmd.respond  = 1'b1;
                  cmd.use_pos  = 1'b1;
                  cmd.rsp_code = ST_FOUND;
                  state_in     = S_IDLE;
               end else begin
                  cmd.probe_next = 1'b1;
                  state_in       = S_READ;
               end
            end
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) begin
               cmd.respond  = clear_rsp_ff;
               cmd.rsp_code = ST_CLEARED;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wipe_ff      <= 1'b1;
         insert_ff    <= 1'b0;
         clear_rsp_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         insert_ff    <= insert_in;
         clear_rsp_ff <= clear_rsp_in;
      end
   end

   a_write_empty : assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> status.slot_empty)
      else $error("slot write issued on an occupied slot");

   a_found_match : assert property (@(posedge clock) disable iff (reset)
      (cmd.respond && cmd.rsp_code == ST_FOUND) |-> status.slot_match)
      else $error("found reported without a key match");

   a_respond_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == S_IDLE))
      else $error("controller not idle after a result");

   a_check_after_read : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ($past(state_ff) == S_READ))
      else $error("slot checked without a preceding read");

endmodule

// ===== verif/open_addressing_hash_table_unit_tb.sv =====
// Self-checking testbench for the open-addressing hash table unit: directed and random items.
`timescale 1ns / 1ps

module open_addressing_hash_table_unit_tb;
   import oaht_pkg::*;

   localparam int SLOTS     = DEF_SLOTS;
   localparam int MAX_CHARS = DEF_MAX_KEY_CHARS;
   localparam int LIMIT     = 1_000_000;
   localparam int PHASES    = 8;
   localparam int RANDOM_PER_PHASE = 206;
   localparam int POOL      = 24;

   localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
   localparam logic [1:0]       PROBE_SPARE = 2'd3;

   // integer_keys and probe_mode for each phase, phase 0 in the low bits
   localparam logic [PHASES-1:0] IK_PLAN = 8'b0100_0111;
   localparam logic [2*PHASES-1:0] PM_PLAN = {PROBE_SPARE, PROBE_SPARE, PROBE_DOUBLE,
      PROBE_QUAD, PROBE_LINEAR, PROBE_DOUBLE, PROBE_QUAD, PROBE_LINEAR};

   class hash_result_board;
      bit [KEY_TEXT_W-1:0] slot_text [SLOTS];
      bit [LEN_W-1:0]      slot_len  [SLOTS];
      bit                  int_keys;
      bit [1:0]            probe;
      bit [RSP_W-1:0]      want_status [$];
      bit [POS_W-1:0]      want_pos [$];
      int                  mismatches;

      function new();
         wipe();
         int_keys   = 1'b1;
         probe      = PROBE_LINEAR;
         mismatches = 0;
      endfunction

      function void wipe();
         foreach (slot_len[i]) begin
            slot_len[i]  = '0;
            slot_text[i] = '0;
         end
      endfunction

      function void apply_register(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] data);
         if (idx == CSR_INTEGER_KEYS) begin
            int_keys = data[0];
            wipe();
         end else begin
            probe = data;
         end
      endfunction

      // shift-fold hash, last character first
      function bit [HASH_W-1:0] fold(bit [KEY_TEXT_W-1:0] text, int unsigned n);
         bit [HASH_W-1:0] h;
         bit [HASH_W-1:0] x;
         h = '0;
         for (int i = int'(n) - 1; i >= 0; i--) begin
            h += HASH_W'(text[8*i +: 8]);
            if (i > 0) begin
               x = (h >> FOLD_TOP) & HASH_W'(FOLD_MASK);
               h = (h << FOLD_BITS) | x;
               h += x << FOLD_ADD;
            end
         end
         return h;
      endfunction

      function bit [31:0] probe_slot(bit [31:0] home, bit [31:0] k, bit [31:0] step);
         bit [31:0] off;
         if (probe == PROBE_QUAD)
            off = k * k;
         else if (probe == PROBE_DOUBLE)
            off = k * step;
         else
            off = k;
         return (home + off) % SLOTS;
      endfunction

      function void note_request(bit [REQ_W-1:0] req, bit [KEY_TEXT_W-1:0] text,
                                 bit [LEN_W-1:0] len, bit [KEY_VALUE_W-1:0] value);
         bit [KEY_TEXT_W-1:0] t;
         int unsigned         n;
         bit [31:0]           h, home, step, idx;
         bit [RSP_W-1:0]      st;
         bit [POS_W-1:0]      pos;
         bit                  done;
         st  = ST_MISSING;
         pos = '0;
         if (req == REQ_CLEAR) begin
            wipe();
            st = ST_CLEARED;
         end else if (req == REQ_INSERT || req == REQ_FIND) begin
            n = len;
            if (n == 0) n = 1;
            if (n > MAX_CHARS) n = MAX_CHARS;
            t = text;
            if (n < 8) t = text & ((64'd1 << (8 * n)) - 64'd1);
            h    = fold(t, n);
            home = int_keys ? (32'(value) % SLOTS) : (h % SLOTS);
            step = (32'(STEP_MOD) - (h % 32'(STEP_MOD))) % 32'(STEP_MOD);
            idx  = home;
            done = 1'b0;
            if (req == REQ_INSERT) st = ST_FULL;
            for (int k = 0; k <= SLOTS && !done; k++) begin
               if (k > 0) begin
                  idx = probe_slot(home, k, step);
                  // back at home: give up
                  if (idx == home) done = 1'b1;
               end
               if (!done) begin
                  if (req == REQ_INSERT) begin
                     if (slot_len[idx] == 0) begin
                        slot_text[idx] = t;
                        slot_len[idx]  = LEN_W'(n);
                        st   = ST_INSERTED;
                        pos  = idx[POS_W-1:0];
                        done = 1'b1;
                     end
                  end else if (slot_len[idx] == 0) begin
                     done = 1'b1;
                  end else if (slot_len[idx] == n && slot_text[idx] == t) begin
                     st   = ST_FOUND;
                     pos  = idx[POS_W-1:0];
                     done = 1'b1;
                  end
               end
            end
         end
         want_status.push_back(st);
         want_pos.push_back(pos);
      endfunction

      function void check_response(bit [RSP_W-1:0] st, bit [POS_W-1:0] pos);
         bit [RSP_W-1:0] exp_st;
         bit [POS_W-1:0] exp_pos;
         if (want_status.size() == 0) begin
            $display("%0t: result with none expected: status %0d position %0d", $time, st, pos);
            mismatches++;
         end else begin
            exp_st  = want_status.pop_front();
            exp_pos = want_pos.pop_front();
            if (st !== exp_st) begin
               $display("%0t: status expected %0d got %0d", $time, exp_st, st);
               mismatches++;
            end
            if (pos !== exp_pos) begin
               $display("%0t: position expected %0d got %0d", $time, exp_pos, pos);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return want_status.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [REQ_W-1:0]       req_type;
   logic [KEY_TEXT_W-1:0]  req_key_text;
   logic [LEN_W-1:0]       req_key_length;
   logic [KEY_VALUE_W-1:0] req_key_value;
   logic                   rsp_valid;
   logic [RSP_W-1:0]       rsp_status;
   logic [POS_W-1:0]       rsp_position;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   hash_result_board board;
   int               cycles = 0;
   bit               idle_on;

   logic [KEY_TEXT_W-1:0]  pool_text  [POOL];
   logic [LEN_W-1:0]       pool_len   [POOL];
   logic [KEY_VALUE_W-1:0] pool_value [POOL];

   open_addressing_hash_table_unit uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_key_text   (req_key_text),
      .req_key_length (req_key_length),
      .req_key_value  (req_key_value),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_position   (rsp_position),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // results are checked before a new item is noted, as both can land on one edge
   always @(posedge clock) begin
      if (!reset && board != null) begin
         if (rsp_valid) board.check_response(rsp_status, rsp_position);
         if (csr_valid && csr_ready) board.apply_register(csr_index, csr_data);
         if (start && !busy)
            board.note_request(req_type, req_key_text, req_key_length, req_key_value);
      end
   end

   function automatic logic [KEY_TEXT_W-1:0] key_chars(input int unsigned n);
      logic [KEY_TEXT_W-1:0] t;
      t = {$urandom, $urandom};
      for (int i = 0; i < 8; i++)
         if (i < n)
            t[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(128, 255))
                                                   : 8'($urandom_range(1, 127));
      return t;
   endfunction

   task automatic send_request(input logic [REQ_W-1:0] rt, input logic [KEY_TEXT_W-1:0] text,
                               input logic [LEN_W-1:0] len,
                               input logic [KEY_VALUE_W-1:0] value);
      if (idle_on && $urandom_range(99) < 16) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= rt;
      req_key_text   <= text;
      req_key_length <= len;
      req_key_value  <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // hold start low until every item has answered, then let the block settle
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic refill_pool();
      for (int i = 0; i < POOL; i++) begin
         pool_len[i]   = LEN_W'($urandom_range(1, MAX_CHARS));
         pool_text[i]  = key_chars(pool_len[i]);
         pool_value[i] = KEY_VALUE_W'($urandom);
      end
   endtask

   task automatic directed_basic();
      send_request(REQ_FIND,   64'h61, 4'd1, 31'd0);
      send_request(REQ_INSERT, 64'h61, 4'd1, 31'd0);
      send_request(REQ_INSERT, 64'h62, 4'd1, 31'd16);
      send_request(REQ_FIND,   64'h62, 4'd1, 31'd16);
      send_request(REQ_INSERT, '1, 4'd8, 31'h7FFF_FFFF);
      send_request(REQ_FIND,   '1, 4'd8, 31'h7FFF_FFFF);
      // zero length reads as one character
      send_request(REQ_INSERT, 64'hDEAD_BEEF_CAFE_0141, 4'd0, 31'd5);
      send_request(REQ_FIND,   64'h41, 4'd1, 31'd5);
      // oversize length saturates
      send_request(REQ_INSERT, 64'h0102_0304_0506_0708, 4'd15, 31'd7);
      send_request(REQ_FIND,   64'h0102_0304_0506_0708, 4'd8, 31'd7);
      send_request(REQ_FIND,   64'h0102_0304_0506_0708, 4'd7, 31'd7);
      send_request(REQ_UNUSED, 64'h61, 4'd1, 31'd0);
      send_request(REQ_CLEAR,  '0, 4'd1, 31'd0);
      send_request(REQ_FIND,   64'h61, 4'd1, 31'd0);
      send_request(REQ_INSERT, 64'h61, 4'd1, 31'd0);
      // stray bytes above the length are ignored
      send_request(REQ_FIND,   64'hFFFF_FFFF_FFFF_FF61, 4'd1, 31'd0);
   endtask

   task automatic directed_double();
      // 'F' hashes to a multiple of seven: zero step
      send_request(REQ_INSERT, 64'h46, 4'd1, 31'd3);
      send_request(REQ_FIND,   64'h46, 4'd1, 31'd3);
      send_request(REQ_INSERT, 64'h47, 4'd1, 31'd3);
      send_request(REQ_INSERT, 64'h47, 4'd1, 31'd3);
      send_request(REQ_FIND,   64'h47, 4'd1, 31'd3);
   endtask

   task automatic run_random(input int count);
      int                     r;
      int                     j;
      int unsigned            n;
      logic [KEY_TEXT_W-1:0]  t;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         j = $urandom_range(POOL - 1);
         if (r < 42) begin
            send_request(REQ_INSERT, pool_text[j], pool_len[j], pool_value[j]);
         end else if (r < 84) begin
            send_request(REQ_FIND, pool_text[j], pool_len[j], pool_value[j]);
         end else if (r < 88) begin
            n = $urandom_range(1, MAX_CHARS);
            t = key_chars(n);
            send_request(($urandom_range(1) != 0) ? REQ_INSERT : REQ_FIND, t, LEN_W'(n),
                         KEY_VALUE_W'($urandom));
         end else if (r < 91) begin
            send_request(REQ_CLEAR, {$urandom, $urandom}, LEN_W'($urandom),
                         KEY_VALUE_W'($urandom));
         end else if (r < 93) begin
            send_request(REQ_UNUSED, {$urandom, $urandom}, LEN_W'($urandom),
                         KEY_VALUE_W'($urandom));
         end else begin
            send_request(REQ_W'($urandom), {$urandom, $urandom}, LEN_W'($urandom),
                         KEY_VALUE_W'($urandom));
         end
      end
   endtask

   initial begin
      board          = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = REQ_INSERT;
      req_key_text   = '0;
      req_key_length = '0;
      req_key_value  = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_INTEGER_KEYS;
      csr_data       = '0;
      idle_on        = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         drain();
         program_register(CSR_INTEGER_KEYS, {1'($urandom_range(1)), IK_PLAN[p]});
         program_register(CSR_PROBE_MODE, PM_PLAN[2*p +: 2]);
         refill_pool();
         // one long stretch without idling
         idle_on = (p != 3);
         if (p == 0) directed_basic();
         if (p == 2) directed_double();
         run_random(RANDOM_PER_PHASE);
      end

      drain();
      repeat (100) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== open_addressing_hash_table_unit.f =====
src/oaht_pkg.sv
src/oaht_ram.sv
src/oaht_rem.sv
src/oaht_dp.sv
src/oaht_ctrl.sv
src/open_addressing_hash_table_unit.sv
verif/open_addressing_hash_table_unit_tb.sv
